// ===== design/tetra_element_stiffness_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TETRA_ELEMENT_STIFFNESS_TOP_DEFINES_SVH
`define TETRA_ELEMENT_STIFFNESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define TES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tes check failed");

// Next-cycle implication, disabled while rst is high.
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tes check failed");

`endif

// ===== design/tes_pkg.sv =====
package tes_pkg;

   localparam int COORD_BITS = 11;
   localparam int DW  = COORD_BITS + 1;      // coordinate difference
   localparam int GW  = 2 * DW + 1;          // cofactor
   localparam int JW  = 3 * DW + 3;          // Jacobian determinant
   localparam int SW  = 2 * GW + 2;          // B^T*D*B entry
   localparam int PW  = JW + SW;             // exact doubled stiffness
   localparam int ENTRY_W = 64;
   localparam int EW  = (PW > ENTRY_W) ? PW : ENTRY_W + 1;
   localparam int SLO = SW / 2;
   localparam int JLO = JW / 2;
   localparam int PP0_W = JLO + SLO;
   localparam int PP1_W = JLO + 1 + SW - SLO;
   localparam int PP2_W = JW - JLO + SLO + 1;
   localparam int PP3_W = JW - JLO + SW - SLO;
   localparam int SHIFT_W = 6;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(24);
   localparam int LANES = 6;
   localparam int NSTG  = 5;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] LAST_HALF = CNT_W'(23);
   localparam logic signed [ENTRY_W-1:0] SAT_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
   localparam logic signed [ENTRY_W-1:0] SAT_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [2:0]              coord_vec_type;
   typedef coord_vec_type [3:0]          coord_set_type;
   typedef logic signed [GW-1:0]         cof_type;
   typedef cof_type [2:0]                vec_type;
   typedef vec_type [3:0]                cof_set_type;

   typedef struct packed {
      logic signed [JW-1:0] jdet;
      cof_set_type          cof;
   } elem_type;

   // node of a matrix row (node-major xyz order)
   function automatic logic [1:0] row_node(input logic [3:0] row);
      logic [1:0] n;
      unique case (row) inside
         4'd0, 4'd1, 4'd2:  n = 2'd0;
         4'd3, 4'd4, 4'd5:  n = 2'd1;
         4'd6, 4'd7, 4'd8:  n = 2'd2;
         default:           n = 2'd3;
      endcase
      return n;
   endfunction

   // axis of a matrix row
   function automatic logic [1:0] row_axis(input logic [3:0] row);
      logic [1:0] a;
      unique case (row) inside
         4'd0, 4'd3, 4'd6, 4'd9:   a = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:  a = 2'd1;
         default:                  a = 2'd2;
      endcase
      return a;
   endfunction

   function automatic cof_type pick(input vec_type v, input logic [1:0] i);
      cof_type r;
      case (i)
         2'd0:    r = v[0];
         2'd1:    r = v[1];
         2'd2:    r = v[2];
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/tes_ifs.sv =====
interface tes_req_if;
   logic                valid;
   logic                ready;
   tes_pkg::coord_type  node1_x;
   tes_pkg::coord_type  node1_y;
   tes_pkg::coord_type  node1_z;
   tes_pkg::coord_type  node2_x;
   tes_pkg::coord_type  node2_y;
   tes_pkg::coord_type  node2_z;
   tes_pkg::coord_type  node3_x;
   tes_pkg::coord_type  node3_y;
   tes_pkg::coord_type  node3_z;
   tes_pkg::coord_type  node4_x;
   tes_pkg::coord_type  node4_y;
   tes_pkg::coord_type  node4_z;

   modport source(output valid, node1_x, node1_y, node1_z, node2_x, node2_y, node2_z,
      node3_x, node3_y, node3_z, node4_x, node4_y, node4_z, input ready);
   modport sink(input valid, node1_x, node1_y, node1_z, node2_x, node2_y, node2_z,
      node3_x, node3_y, node3_z, node4_x, node4_y, node4_z, output ready);
endinterface

interface tes_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [3:0]                  row_index;
   logic                        col_base;
   logic signed [63:0]          entry_0;
   logic signed [63:0]          entry_1;
   logic signed [63:0]          entry_2;
   logic signed [63:0]          entry_3;
   logic signed [63:0]          entry_4;
   logic signed [63:0]          entry_5;
   logic                        last_of_matrix;

   modport source(output valid, row_index, col_base, entry_0, entry_1, entry_2,
      entry_3, entry_4, entry_5, last_of_matrix, input ready);
   modport sink(input valid, row_index, col_base, entry_0, entry_1, entry_2,
      entry_3, entry_4, entry_5, last_of_matrix, output ready);
endinterface

interface tes_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] result_shift;

   modport source(output valid, result_shift, input ready);
   modport sink(input valid, result_shift, output ready);
endinterface

// ===== design/tes_geom.sv =====
module tes_geom (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tes_pkg::coord_set_type crd,
   output logic                   in_ready,
   output logic                   elem_valid,
   output tes_pkg::elem_type      elem,
   input  logic                   take
);
   import tes_pkg::*;

   logic                       gadv;
   logic [5:0]                 vg_ff;
   coord_set_type              crd_ff;
   logic signed [DW-1:0]       dm_ff [3][4][4];
   logic signed [2*DW-1:0]     t1_ff [4][3];
   logic signed [2*DW-1:0]     t2_ff [4][3];
   logic signed [2*DW-1:0]     u1_ff [3];
   logic signed [2*DW-1:0]     u2_ff [3];
   logic signed [DW-1:0]       xd3_ff [3];
   logic signed [DW-1:0]       xd4_ff [3];
   cof_set_type                cof4_ff;
   cof_set_type                cof5_ff;
   cof_type                    ui_ff [3];
   logic signed [DW+GW-1:0]    jp_ff [3];
   elem_type                   elem_ff;

   function automatic logic signed [2*DW-1:0] mul_d(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      return a * b;
   endfunction

   assign gadv       = !vg_ff[5] || take;
   assign in_ready   = gadv;
   assign elem_valid = vg_ff[5];
   assign elem       = elem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= '0;
      end else if (gadv) begin
         vg_ff <= {vg_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (gadv) begin
         // capture corners
         crd_ff <= crd;
         // all pairwise differences per axis
         for (int a = 0; a < 3; a++) begin
            for (int p = 0; p < 4; p++) begin
               for (int q = 0; q < 4; q++) begin
                  dm_ff[a][p][q] <= DW'(crd_ff[p][a]) - DW'(crd_ff[q][a]);
               end
            end
         end
         // cofactor product terms
         t1_ff[0][0] <= mul_d(dm_ff[1][3][1], dm_ff[2][2][1]);
         t2_ff[0][0] <= mul_d(dm_ff[1][2][1], dm_ff[2][3][1]);
         t1_ff[0][1] <= mul_d(dm_ff[0][2][1], dm_ff[2][3][1]);
         t2_ff[0][1] <= mul_d(dm_ff[0][3][1], dm_ff[2][2][1]);
         t1_ff[0][2] <= mul_d(dm_ff[0][3][1], dm_ff[1][2][1]);
         t2_ff[0][2] <= mul_d(dm_ff[0][2][1], dm_ff[1][3][1]);
         t1_ff[1][0] <= mul_d(dm_ff[1][2][0], dm_ff[2][3][2]);
         t2_ff[1][0] <= mul_d(dm_ff[1][2][3], dm_ff[2][0][2]);
         t1_ff[1][1] <= mul_d(dm_ff[0][3][2], dm_ff[2][2][0]);
         t2_ff[1][1] <= mul_d(dm_ff[0][0][2], dm_ff[2][2][3]);
         t1_ff[1][2] <= mul_d(dm_ff[0][2][0], dm_ff[1][3][2]);
         t2_ff[1][2] <= mul_d(dm_ff[0][2][3], dm_ff[1][0][2]);
         t1_ff[2][0] <= mul_d(dm_ff[1][1][3], dm_ff[2][0][3]);
         t2_ff[2][0] <= mul_d(dm_ff[1][0][3], dm_ff[2][1][3]);
         t1_ff[2][1] <= mul_d(dm_ff[0][0][3], dm_ff[2][1][3]);
         t2_ff[2][1] <= mul_d(dm_ff[0][1][3], dm_ff[2][0][3]);
         t1_ff[2][2] <= mul_d(dm_ff[0][1][3], dm_ff[1][0][3]);
         t2_ff[2][2] <= mul_d(dm_ff[0][0][3], dm_ff[1][1][3]);
         t1_ff[3][0] <= mul_d(dm_ff[1][0][2], dm_ff[2][1][0]);
         t2_ff[3][0] <= mul_d(dm_ff[1][0][1], dm_ff[2][2][0]);
         t1_ff[3][1] <= mul_d(dm_ff[0][1][0], dm_ff[2][0][2]);
         t2_ff[3][1] <= mul_d(dm_ff[0][2][0], dm_ff[2][0][1]);
         t1_ff[3][2] <= mul_d(dm_ff[0][0][2], dm_ff[1][1][0]);
         t2_ff[3][2] <= mul_d(dm_ff[0][0][1], dm_ff[1][2][0]);
         // determinant inner terms
         u1_ff[0]  <= mul_d(dm_ff[1][1][2], dm_ff[2][2][3]);
         u2_ff[0]  <= mul_d(dm_ff[1][2][3], dm_ff[2][1][2]);
         u1_ff[1]  <= mul_d(dm_ff[1][2][3], dm_ff[2][0][1]);
         u2_ff[1]  <= mul_d(dm_ff[1][0][1], dm_ff[2][2][3]);
         u1_ff[2]  <= mul_d(dm_ff[1][0][1], dm_ff[2][1][2]);
         u2_ff[2]  <= mul_d(dm_ff[1][1][2], dm_ff[2][0][1]);
         xd3_ff[0] <= dm_ff[0][1][0];
         xd3_ff[1] <= dm_ff[0][2][1];
         xd3_ff[2] <= dm_ff[0][3][2];
         // cofactors and inner differences
         for (int n = 0; n < 4; n++) begin
            for (int c = 0; c < 3; c++) begin
               cof4_ff[n][c] <= GW'(t1_ff[n][c]) - GW'(t2_ff[n][c]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            ui_ff[i]  <= GW'(u1_ff[i]) - GW'(u2_ff[i]);
            xd4_ff[i] <= xd3_ff[i];
            jp_ff[i]  <= (DW+GW)'(xd4_ff[i]) * (DW+GW)'(ui_ff[i]);
         end
         cof5_ff <= cof4_ff;
         // sum up the determinant
         elem_ff.cof  <= cof5_ff;
         elem_ff.jdet <= JW'(jp_ff[0]) + JW'(jp_ff[1]) + JW'(jp_ff[2]);
      end
   end

endmodule

// ===== design/tes_lane.sv =====
module tes_lane (
   input  logic                                clock,
   input  logic                                adv,
   input  tes_pkg::vec_type                    gm,
   input  tes_pkg::vec_type                    gn,
   input  logic [1:0]                          p,
   input  logic [1:0]                          q,
   input  logic signed [tes_pkg::JW-1:0]       jdet,
   input  logic [tes_pkg::SHIFT_W-1:0]         shift,
   output logic signed [tes_pkg::ENTRY_W-1:0]  entry
);
   import tes_pkg::*;

   logic signed [GW-1:0]    op_a [3];
   logic signed [GW-1:0]    op_b [3];
   logic                    diag;
   logic signed [2*GW-1:0]  pr_ff [3];
   logic                    diag_ff;
   logic [1:0]              p_ff;
   logic signed [JW-1:0]    j1_ff;
   logic signed [JW-1:0]    j2_ff;
   logic signed [SW-1:0]    s_ff;
   logic signed [2*GW-1:0]  extra;
   logic [PP0_W-1:0]        pp0_ff;
   logic signed [PP1_W-1:0] pp1_ff;
   logic signed [PP2_W-1:0] pp2_ff;
   logic signed [PP3_W-1:0] pp3_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [EW-1:0]    sh_ff;
   logic [EW-ENTRY_W:0]     top_bits;

   // equal axes (p == q): dot product plus the own-axis term; unequal axes: one cross term
   always_comb begin
      diag = (p == q);
      for (int o = 0; o < 3; o++) begin
         op_a[o] = '0;
         op_b[o] = '0;
      end
      if (diag) begin
         for (int o = 0; o < 3; o++) begin
            op_a[o] = gm[o];
            op_b[o] = gn[o];
         end
      end else begin
         op_a[0] = pick(gm, q);
         op_b[0] = pick(gn, p);
      end
   end

   always_comb begin
      case (p_ff)
         2'd0:    extra = pr_ff[0];
         2'd1:    extra = pr_ff[1];
         2'd2:    extra = pr_ff[2];
         default: extra = '0;
      endcase
      if (!diag_ff) begin
         extra = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int o = 0; o < 3; o++) begin
            pr_ff[o] <= op_a[o] * op_b[o];
         end
         diag_ff <= diag;
         p_ff    <= p;
         j1_ff   <= jdet;
         s_ff    <= SW'(pr_ff[0]) + SW'(pr_ff[1]) + SW'(pr_ff[2]) + SW'(extra);
         j2_ff   <= j1_ff;
         // partial products of jdet * s
         pp0_ff  <= PP0_W'(j2_ff[JLO-1:0]) * PP0_W'(s_ff[SLO-1:0]);
         pp1_ff  <= PP1_W'($signed({1'b0, j2_ff[JLO-1:0]})) * PP1_W'($signed(s_ff[SW-1:SLO]));
         pp2_ff  <= PP2_W'($signed(j2_ff[JW-1:JLO])) * PP2_W'($signed({1'b0, s_ff[SLO-1:0]}));
         pp3_ff  <= PP3_W'($signed(j2_ff[JW-1:JLO])) * PP3_W'($signed(s_ff[SW-1:SLO]));
         prod_ff <= PW'($signed({1'b0, pp0_ff}))
                  + (PW'(pp1_ff) <<< SLO)
                  + (PW'(pp2_ff) <<< JLO)
                  + (PW'(pp3_ff) <<< (JLO + SLO));
         sh_ff   <= EW'(prod_ff) >>> shift;
      end
   end

   // saturate to the signed entry range
   always_comb begin
      top_bits = sh_ff[EW-1:ENTRY_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         entry = sh_ff[ENTRY_W-1:0];
      end else if (sh_ff[EW-1]) begin
         entry = SAT_MIN;
      end else begin
         entry = SAT_MAX;
      end
   end

endmodule

// ===== design/tetra_element_stiffness_top.sv =====
// Tetrahedron element stiffness engine.
// req: one word carries the four corner nodes as twelve signed coordinates.
// rsp: each element returns 24 words, one half-row of the doubled stiffness
//   matrix each, row 0 cols 0..5, row 0 cols 6..11, row 1 ... row 11;
//   last_of_matrix marks the 24th word.
// csr: write-only result_shift, always ready; write only while idle.
// rsp: one word per cycle while rsp is ready; six lanes build the six
//   entries of a half-row in parallel, and the half-row sequencer is the
//   pace setter.
// A new request is taken while the previous element still streams out; the
//   geometry pipe holds up to six elements in flight.
// When rsp stalls, the lanes, the sequencer and the output register hold;
//   once the finished element waits in the geometry pipe, req_ready drops.
// Reset clears all valid bits and restores result_shift to 24.
module tetra_element_stiffness_top (
   input  logic     clock,
   input  logic     reset,
   tes_req_if.sink  req,
   tes_rsp_if.source rsp,
   tes_csr_if.sink  csr
);
   import tes_pkg::*;

   logic [SHIFT_W-1:0]       shift_ff;
   coord_set_type            crd;
   logic                     elem_valid;
   elem_type                 elem;
   logic                     take;
   logic                     adv;

   // sequencer
   logic                     busy_ff, busy_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   elem_type                 cur_ff, cur_in;
   logic [3:0]               row;
   logic                     half;

   // lane sideband pipe
   logic [NSTG-1:0]          v_ff;
   logic [3:0]               row_ff [NSTG];
   logic                     half_ff [NSTG];
   logic                     last_ff [NSTG];
   logic signed [ENTRY_W-1:0] lane_entry [LANES];

   // output register
   logic                     rsp_valid_ff;
   logic [3:0]               rsp_row_ff;
   logic                     rsp_col_ff;
   logic                     rsp_last_ff;
   logic signed [ENTRY_W-1:0] rsp_entry_ff [LANES];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr.valid) begin
         shift_ff <= csr.result_shift;
      end
   end

   assign crd[0][0] = req.node1_x;
   assign crd[0][1] = req.node1_y;
   assign crd[0][2] = req.node1_z;
   assign crd[1][0] = req.node2_x;
   assign crd[1][1] = req.node2_y;
   assign crd[1][2] = req.node2_z;
   assign crd[2][0] = req.node3_x;
   assign crd[2][1] = req.node3_y;
   assign crd[2][2] = req.node3_z;
   assign crd[3][0] = req.node4_x;
   assign crd[3][1] = req.node4_y;
   assign crd[3][2] = req.node4_z;

   tes_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .crd        (crd),
      .in_ready   (req.ready),
      .elem_valid (elem_valid),
      .elem       (elem),
      .take       (take)
   );

   // whole back end advances when the output register is free or drains
   assign adv  = !rsp_valid_ff || rsp.ready;
   assign take = adv && (!busy_ff || (cnt_ff == LAST_HALF));

   assign row  = cnt_ff[CNT_W-1:1];
   assign half = cnt_ff[0];

   // advance through the 24 half-rows; load the next element on the last one or when idle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      cur_in  = cur_ff;
      if (adv) begin
         if (busy_ff && (cnt_ff != LAST_HALF)) begin
            cnt_in = cnt_ff + 1'b1;
         end else if (elem_valid) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            cur_in  = elem;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      cur_ff <= cur_in;
   end

   // six lanes, one per entry of the half-row
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [1:0] node_n;
      assign node_n = {half, 1'(i / 3)};

      tes_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .gm    (cur_ff.cof[row_node(row)]),
         .gn    (cur_ff.cof[node_n]),
         .p     (row_axis(row)),
         .q     (2'(i % 3)),
         .jdet  (cur_ff.jdet),
         .shift (shift_ff),
         .entry (lane_entry[i])
      );
   end

   // carry row tags alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], busy_ff};
      end
      if (adv) begin
         row_ff[0]  <= row;
         half_ff[0] <= half;
         last_ff[0] <= (cnt_ff == LAST_HALF);
         for (int s = 1; s < NSTG; s++) begin
            row_ff[s]  <= row_ff[s-1];
            half_ff[s] <= half_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   // output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[NSTG-1];
      end
      if (adv) begin
         rsp_row_ff  <= row_ff[NSTG-1];
         rsp_col_ff  <= half_ff[NSTG-1];
         rsp_last_ff <= last_ff[NSTG-1];
         for (int j = 0; j < LANES; j++) begin
            rsp_entry_ff[j] <= lane_entry[j];
         end
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.row_index      = rsp_row_ff;
   assign rsp.col_base       = rsp_col_ff;
   assign rsp.last_of_matrix = rsp_last_ff;
   assign rsp.entry_0        = rsp_entry_ff[0];
   assign rsp.entry_1        = rsp_entry_ff[1];
   assign rsp.entry_2        = rsp_entry_ff[2];
   assign rsp.entry_3        = rsp_entry_ff[3];
   assign rsp.entry_4        = rsp_entry_ff[4];
   assign rsp.entry_5        = rsp_entry_ff[5];

endmodule

// ===== design/tes_checker.sv =====
`include "tetra_element_stiffness_top_defines.svh"

module tes_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_row_index,
   input logic       rsp_col_base,
   input logic       rsp_last
);

   // hold the row index and column half of a stalled word
   `TES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_index) && $stable(rsp_col_base))

   // second half of a row follows the first without a gap
   `TES_ASSERT_NEXT(a_half_pair, clock, reset, rsp_valid && rsp_ready && !rsp_col_base, rsp_valid && rsp_col_base && (rsp_row_index == $past(rsp_row_index)))

   // a new matrix starts at row 0, first half
   `TES_ASSERT_NEXT(a_new_matrix, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid || ((rsp_row_index == 4'd0) && !rsp_col_base))

   // drop rsp valid after reset
   `TES_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind tetra_element_stiffness_top tes_checker u_tes_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_row_index (rsp.row_index),
   .rsp_col_base  (rsp.col_base),
   .rsp_last      (rsp.last_of_matrix)
);
